// ----- design/mst_pkg.sv -----
`timescale 1ns / 1ps
package mst_pkg;
  localparam int ADDR_BITS = 23;
  localparam int OFF_BITS = 24;
  localparam logic [31:0] PAT_A = 32'haaaaaaaa;
  localparam logic [31:0] PAT_5 = 32'h55555555;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_WACK = 2'd1;
  localparam logic [1:0] OP_RDATA = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_IDLE = 2'd2;

  localparam logic [2:0] REG_BASE = 3'd0;
  localparam logic [2:0] REG_WORDS = 3'd1;
  localparam logic [2:0] REG_ENABLE = 3'd2;
  localparam logic [2:0] REG_PASSES = 3'd3;
  localparam logic [2:0] REG_SEED = 3'd4;

  typedef enum logic [23:0] {
    PH_IDLE    = 24'h000001,
    D_W0       = 24'h000002,
    D_R0       = 24'h000004,
    D_W1       = 24'h000008,
    D_R1       = 24'h000010,
    D_WW       = 24'h000020,
    D_RW       = 24'h000040,
    D_WZ       = 24'h000080,
    D_RZ       = 24'h000100,
    A_FILL     = 24'h000200,
    A_WBASE    = 24'h000400,
    A_CHK1     = 24'h000800,
    A_RESTORE  = 24'h001000,
    A_PWRITE   = 24'h002000,
    A_RBASE    = 24'h004000,
    A_RSCAN    = 24'h008000,
    A_PRESTORE = 24'h010000,
    I_FILL     = 24'h020000,
    I_CHK      = 24'h040000,
    I_INV      = 24'h080000,
    I_CHK2     = 24'h100000,
    I_ZERO     = 24'h200000,
    S_WRITE    = 24'h400000,
    S_READ     = 24'h800000
  } phase_t;
endpackage

// ----- design/memory_self_test_sequencer.sv -----
`timescale 1ns / 1ps
// Each accepted word is decoded combinationally and its answer is registered in the
// output register, or in the skid register when the output stalls.
// A new word is accepted every cycle while answers drain; when an answer stalls, one
// more word is held in a skid register and the input then waits until it drains.
// Synchronous active-low reset returns the sequencer to idle and the configuration
// registers to their defaults.
module memory_self_test_sequencer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // opcode[1:0], read_data[33:2], zero fill
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // command, mem_addr, write_data, check_fail, test_id,
                                   // bus_line, expected_word, actual_word, fault_addr,
                                   // run_failed, zero fill
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import mst_pkg::*;

  logic [22:0] base_r;
  logic [23:0] words_r;
  logic [3:0]  enable_r;
  logic [7:0]  passes_r;
  logic [31:0] seed_r;

  phase_t      ph_r, ph_nxt;
  logic [23:0] off_r, off_nxt, probe_r, probe_nxt;
  logic [31:0] walk_r, walk_nxt, pat_r, pat_nxt, pend_r, pend_nxt;
  logic [4:0]  line_r, line_nxt;
  logic        desc_r, desc_nxt, fail_r, fail_nxt;
  logic [7:0]  left_r, left_nxt;

  logic [152:0] res_nxt, out_r, skid_r;
  logic         out_v_r, skid_v_r;
  logic         take;

  assign in_tready = !skid_v_r;
  assign take = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata = {7'd0, out_r};

  logic [23:0] cnt, msk;
  assign cnt = (words_r == 24'd0) ? 24'd1 : words_r;
  assign msk = cnt - 24'd1;

  function automatic logic [4:0] low_bit(input logic [31:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 31; i >= 0; i--) if (v[i]) r = 5'(i);
    return r;
  endfunction

  function automatic logic [1:0] ph_test(input phase_t p);
    logic [1:0] t;
    case (p) inside
      D_W0, D_R0, D_W1, D_R1, D_WW, D_RW, D_WZ, D_RZ: t = 2'd0;
      A_FILL, A_WBASE, A_CHK1, A_RESTORE, A_PWRITE, A_RBASE, A_RSCAN, A_PRESTORE: t = 2'd1;
      I_FILL, I_CHK, I_INV, I_CHK2, I_ZERO: t = 2'd2;
      default: t = 2'd3;
    endcase
    return t;
  endfunction

  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] off;
    logic [31:0] data;
  } desc_t;

  function automatic desc_t describe(input phase_t p, input logic [23:0] o,
                                     input logic [23:0] pr, input logic [31:0] w);
    desc_t d;
    d = '{cmd: CMD_IDLE, off: 24'd0, data: 32'd0};
    unique case (p)
      D_W0: d.cmd = CMD_WRITE;
      D_R0: d.cmd = CMD_READ;
      D_W1: d = '{CMD_WRITE, 24'd0, 32'hffffffff};
      D_R1: d = '{CMD_READ, 24'd0, 32'hffffffff};
      D_WW: d = '{CMD_WRITE, 24'd0, w};
      D_RW: d = '{CMD_READ, 24'd0, w};
      D_WZ: d = '{CMD_WRITE, 24'd0, ~w};
      D_RZ: d = '{CMD_READ, 24'd0, ~w};
      A_FILL: d = '{CMD_WRITE, o, PAT_A};
      A_WBASE: d = '{CMD_WRITE, 24'd0, PAT_5};
      A_CHK1: d = '{CMD_READ, o, PAT_A};
      A_RESTORE: d = '{CMD_WRITE, 24'd0, PAT_A};
      A_PWRITE: d = '{CMD_WRITE, pr, PAT_5};
      A_RBASE: d = '{CMD_READ, 24'd0, PAT_A};
      A_RSCAN: d = '{CMD_READ, o, PAT_A};
      A_PRESTORE: d = '{CMD_WRITE, pr, PAT_A};
      I_FILL: d = '{CMD_WRITE, o, {8'd0, o} + 32'd1};
      I_CHK: d = '{CMD_READ, o, {8'd0, o} + 32'd1};
      I_INV: d = '{CMD_WRITE, o, ~({8'd0, o} + 32'd1)};
      I_CHK2: d = '{CMD_READ, o, ~({8'd0, o} + 32'd1)};
      I_ZERO: d = '{CMD_WRITE, o, 32'd0};
      S_WRITE: d = '{CMD_WRITE, o, w};
      S_READ: d = '{CMD_READ, o, w};
      default: d.cmd = CMD_IDLE;
    endcase
    return d;
  endfunction

  logic [1:0]  op;
  logic [31:0] rd;
  desc_t       cur, nd;
  logic        fail, do_start;
  logic [2:0]  start_id;
  logic [1:0]  rep_test;
  logic [4:0]  rep_line;
  logic [22:0] rep_addr;
  logic [23:0] sh_off, inc_off;
  logic [31:0] sw_walk, ip;

  assign op = in_tdata[1:0];
  assign rd = in_tdata[33:2];
  assign cur = describe(ph_r, off_r, probe_r, walk_r);
  assign sh_off = {off_r[22:0], 1'b0};
  assign inc_off = off_r + 24'd1;
  assign sw_walk = desc_r ? walk_r - 32'd1 : walk_r + 32'd1;
  assign ip = pat_r[31] ? 32'd0 - pat_r : ~pat_r;

  always_comb begin
    ph_nxt = ph_r; off_nxt = off_r; probe_nxt = probe_r; walk_nxt = walk_r;
    pat_nxt = pat_r; pend_nxt = pend_r; line_nxt = line_r; desc_nxt = desc_r;
    fail_nxt = fail_r; left_nxt = left_r;
    fail = 1'b0; do_start = 1'b0; start_id = 3'd0;
    rep_test = 2'd0; rep_line = 5'd0; rep_addr = 23'd0;
    if (op == OP_START) begin
      fail_nxt = 1'b0; do_start = 1'b1; start_id = 3'd0;
    end else if (op == OP_WACK && cur.cmd == CMD_WRITE) begin
      unique case (ph_r)
        D_W0: ph_nxt = D_R0;
        D_W1: ph_nxt = D_R1;
        D_WW: ph_nxt = D_RW;
        D_WZ: ph_nxt = D_RZ;
        A_FILL: begin
          off_nxt = sh_off;
          ph_nxt = ((sh_off & msk) != 0) ? A_FILL : A_WBASE;
        end
        A_WBASE: begin
          off_nxt = 24'd1; line_nxt = 5'd2;
          ph_nxt = msk[0] ? A_CHK1 : A_RESTORE;
        end
        A_RESTORE: begin
          probe_nxt = 24'd1;
          if (msk[0]) ph_nxt = A_PWRITE;
          else begin do_start = 1'b1; start_id = 3'd2; end
        end
        A_PWRITE: ph_nxt = A_RBASE;
        A_PRESTORE: begin
          probe_nxt = {probe_r[22:0], 1'b0};
          if (({probe_r[22:0], 1'b0} & msk) != 0) ph_nxt = A_PWRITE;
          else begin do_start = 1'b1; start_id = 3'd2; end
        end
        I_FILL: begin
          off_nxt = inc_off;
          if (inc_off >= cnt) begin off_nxt = 24'd0; ph_nxt = I_CHK; end
        end
        I_INV: begin
          off_nxt = inc_off;
          if (inc_off >= cnt) begin off_nxt = 24'd0; ph_nxt = I_CHK2; end
          else ph_nxt = I_CHK;
        end
        I_ZERO: begin
          off_nxt = inc_off;
          if (inc_off >= cnt) begin do_start = 1'b1; start_id = 3'd3; end
          else ph_nxt = I_CHK2;
        end
        S_WRITE: begin
          walk_nxt = sw_walk; off_nxt = inc_off;
          if (inc_off >= cnt) begin
            off_nxt = 24'd0; walk_nxt = pat_r; ph_nxt = S_READ;
          end
        end
        default: ;
      endcase
    end else if (op == OP_RDATA && cur.cmd == CMD_READ) begin
      fail = (rd != pend_r) && !(ph_r == A_RSCAN && off_r == probe_r);
      if (fail) begin
        fail_nxt = 1'b1;
        rep_test = ph_test(ph_r);
        rep_line = line_r;
        rep_addr = base_r + cur.off[22:0];
      end
      unique case (ph_r)
        D_R0, D_R1: begin
          if (fail) begin
            rep_line = low_bit(rd ^ pend_r); do_start = 1'b1; start_id = 3'd1;
          end else if (ph_r == D_R0) ph_nxt = D_W1;
          else begin walk_nxt = 32'd1; line_nxt = 5'd0; ph_nxt = D_WW; end
        end
        D_RW: if (fail) begin do_start = 1'b1; start_id = 3'd1; end
              else ph_nxt = D_WZ;
        D_RZ: begin
          if (fail) begin do_start = 1'b1; start_id = 3'd1; end
          else begin
            walk_nxt = {walk_r[30:0], 1'b0}; line_nxt = line_r + 5'd1;
            if (walk_r[30:0] == 31'd0) begin do_start = 1'b1; start_id = 3'd1; end
            else ph_nxt = D_WW;
          end
        end
        A_CHK1, A_RSCAN: begin
          if (fail) begin do_start = 1'b1; start_id = 3'd2; end
          else begin
            off_nxt = sh_off; line_nxt = line_r + 5'd1;
            if ((sh_off & msk) == 0) ph_nxt = (ph_r == A_CHK1) ? A_RESTORE : A_PRESTORE;
          end
        end
        A_RBASE: begin
          if (fail) begin
            rep_line = 5'd2 + low_bit({8'd0, probe_r}); do_start = 1'b1; start_id = 3'd2;
          end else begin
            off_nxt = 24'd1; line_nxt = 5'd2;
            ph_nxt = msk[0] ? A_RSCAN : A_PRESTORE;
          end
        end
        I_CHK: if (fail) begin do_start = 1'b1; start_id = 3'd3; end
               else ph_nxt = I_INV;
        I_CHK2: if (fail) begin do_start = 1'b1; start_id = 3'd3; end
                else ph_nxt = I_ZERO;
        S_READ: begin
          walk_nxt = sw_walk; off_nxt = inc_off;
          if (inc_off >= cnt) begin
            pat_nxt = ip; desc_nxt = !desc_r;
            if (left_r <= 8'd1) begin left_nxt = 8'd0; ph_nxt = PH_IDLE; end
            else begin
              left_nxt = left_r - 8'd1; off_nxt = 24'd0; walk_nxt = ip; ph_nxt = S_WRITE;
            end
          end
        end
        default: ;
      endcase
    end
    if (do_start) begin
      if (start_id == 3'd0 && enable_r[0]) ph_nxt = D_W0;
      else if (start_id <= 3'd1 && enable_r[1]) begin
        off_nxt = 24'd1; ph_nxt = msk[0] ? A_FILL : A_WBASE;
      end else if (start_id <= 3'd2 && enable_r[2]) begin
        off_nxt = 24'd0; ph_nxt = I_FILL;
      end else if (enable_r[3] && passes_r != 8'd0) begin
        left_nxt = passes_r; pat_nxt = seed_r; desc_nxt = 1'b0; walk_nxt = seed_r;
        off_nxt = 24'd0; ph_nxt = S_WRITE;
      end else ph_nxt = PH_IDLE;
    end
    nd = describe(ph_nxt, off_nxt, probe_nxt, walk_nxt);
    if (nd.cmd == CMD_READ) pend_nxt = nd.data;
    res_nxt = {fail_nxt, rep_addr, (fail ? rd : 32'd0), (fail ? pend_r : 32'd0),
               rep_line, rep_test, fail,
               (nd.cmd == CMD_WRITE ? nd.data : 32'd0),
               (nd.cmd == CMD_IDLE ? 23'd0 : base_r + nd.off[22:0]), nd.cmd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0; words_r <= 24'd8388608; enable_r <= 4'hf;
      passes_r <= 8'd100; seed_r <= '0;
      ph_r <= PH_IDLE; off_r <= '0; probe_r <= '0; walk_r <= 32'd1; pat_r <= '0;
      pend_r <= '0; line_r <= '0; desc_r <= 1'b0; fail_r <= 1'b0; left_r <= '0;
      out_v_r <= 1'b0; skid_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE: base_r <= cfg_data[22:0];
          REG_WORDS: words_r <= cfg_data[23:0];
          REG_ENABLE: enable_r <= cfg_data[3:0];
          REG_PASSES: passes_r <= cfg_data[7:0];
          REG_SEED: seed_r <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        ph_r <= ph_nxt; off_r <= off_nxt; probe_r <= probe_nxt; walk_r <= walk_nxt;
        pat_r <= pat_nxt; pend_r <= pend_nxt; line_r <= line_nxt; desc_r <= desc_nxt;
        fail_r <= fail_nxt; left_r <= left_nxt;
      end
      if (!out_v_r || out_tready) begin
        out_v_r <= skid_v_r || take;
        skid_v_r <= 1'b0;
      end else if (take) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) out_r <= skid_v_r ? skid_r : res_nxt;
    if (take && out_v_r && !out_tready) skid_r <= res_nxt;
  end
endmodule

// ----- design/mst_checker.sv -----
`timescale 1ns / 1ps
module mst_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata
);
  import mst_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("word dropped or changed while stalled");
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == CMD_IDLE |-> out_tdata[56:2] == 55'd0)
    else $error("idle answer carries address or data");
  a_nofail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[57] |-> out_tdata[151:58] == 94'd0)
    else $error("failure report without check_fail");
  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[57] |-> out_tdata[152])
    else $error("run_failed not set with check_fail");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted word produced no answer");
endmodule

bind memory_self_test_sequencer mst_checker u_mst_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
